>>> design/sbrb_pkg.sv
// Shared codes and types for the seekable byte ring buffer.
// Used by sbrb_ctrl, sbrb_datapath and seekable_byte_ring_buffer_unit.
package sbrb_pkg;

    // Input action codes
    localparam logic [2:0] ACT_WRITE = 3'd0;
    localparam logic [2:0] ACT_READ  = 3'd1;
    localparam logic [2:0] ACT_SEEK  = 3'd2;
    localparam logic [2:0] ACT_EOF   = 3'd3;
    localparam logic [2:0] ACT_RESET = 3'd4;

    // Result kind codes
    localparam logic [2:0] K_WACK   = 3'd0;
    localparam logic [2:0] K_RBYTE  = 3'd1;
    localparam logic [2:0] K_REMPTY = 3'd2;
    localparam logic [2:0] K_SOK    = 3'd3;
    localparam logic [2:0] K_SFAIL  = 3'd4;
    localparam logic [2:0] K_DONE   = 3'd5;

    // Seek origin codes
    localparam logic [1:0] SEEK_START = 2'd0;
    localparam logic [1:0] SEEK_CUR   = 2'd1;
    localparam logic [1:0] SEEK_END   = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILE_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SESSION_ID = 2'd1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;    // latch the accepted input item
        logic wr_do;      // store a byte and post the write ack
        logic rd_start;   // size the read, update count and position
        logic rd_short;   // post an empty or done read result
        logic rd_fetch;   // read the store at the read pointer
        logic rd_emit;    // post one read byte and advance
        logic sk_calc;    // compute the seek target
        logic sk_finish;  // check the target, apply and post the seek result
        logic misc_do;    // set eof, reset or unknown action
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;   // output register can take a result this cycle
        logic rd_none;    // the read being started moves no byte
        logic rd_last;    // one byte left in the running read
    } dp_status_t;

endpackage

>>> design/sbrb_ctrl.sv
// Controller state machine for the seekable byte ring buffer.
// Depends on sbrb_pkg for the command/status structs and action codes.
module sbrb_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  logic [2:0]            in_action,
    input  sbrb_pkg::dp_status_t  st,
    output logic                  in_ready,
    output sbrb_pkg::dp_cmd_t     cmd
);
    import sbrb_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_WRITE    = 9'b000000010,
        ST_MISC     = 9'b000000100,
        ST_RD_START = 9'b000001000,
        ST_RD_SHORT = 9'b000010000,
        ST_RD_ADDR  = 9'b000100000,
        ST_RD_EMIT  = 9'b001000000,
        ST_SK_CALC  = 9'b010000000,
        ST_SK_DONE  = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Sequence one item at a time
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    priority if (in_action == ACT_WRITE) state_next = ST_WRITE;
                    else if (in_action == ACT_READ)      state_next = ST_RD_START;
                    else if (in_action == ACT_SEEK)      state_next = ST_SK_CALC;
                    else                                 state_next = ST_MISC;
                end
            end
            ST_WRITE: begin
                if (st.out_free) begin
                    cmd.wr_do  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_MISC: begin
                if (st.out_free) begin
                    cmd.misc_do = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_RD_START: begin
                cmd.rd_start = 1'b1;
                state_next   = st.rd_none ? ST_RD_SHORT : ST_RD_ADDR;
            end
            ST_RD_SHORT: begin
                if (st.out_free) begin
                    cmd.rd_short = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_RD_ADDR: begin
                cmd.rd_fetch = 1'b1;
                state_next   = ST_RD_EMIT;
            end
            ST_RD_EMIT: begin
                if (st.out_free) begin
                    cmd.rd_emit = 1'b1;
                    state_next  = st.rd_last ? ST_IDLE : ST_RD_ADDR;
                end
            end
            ST_SK_CALC: begin
                cmd.sk_calc = 1'b1;
                state_next  = ST_SK_DONE;
            end
            ST_SK_DONE: begin
                if (st.out_free) begin
                    cmd.sk_finish = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> design/sbrb_datapath.sv
// Datapath of the seekable byte ring buffer: byte store, pointers, counters,
// seek arithmetic, configuration registers and the result register.
// Depends on sbrb_pkg for codes and the command/status structs.
module sbrb_datapath #(
    parameter int unsigned CAPACITY = 4096,
    parameter int unsigned MAX_READ = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  sbrb_pkg::dp_cmd_t                   cmd,
    output sbrb_pkg::dp_status_t                st,
    // configuration writes
    input  logic                                cfg_we,
    input  logic [sbrb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                         cfg_data,
    // input item
    input  logic [2:0]                          in_action,
    input  logic [7:0]                          in_data_byte,
    input  logic                                in_chunk_last,
    input  logic [6:0]                          in_read_length,
    input  logic [1:0]                          in_seek_mode,
    input  logic [32:0]                         in_seek_offset,
    input  logic                                in_eof_value,
    // result item
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [2:0]                          out_kind,
    output logic [7:0]                          out_read_byte,
    output logic                                out_last,
    output logic                                out_accepted,
    output logic [31:0]                         out_position,
    output logic                                out_seek_request,
    output logic                                out_data_request,
    output logic [12:0]                         out_unread_count,
    output logic [31:0]                         out_session_tag,
    output logic                                seeking
);
    import sbrb_pkg::*;

    localparam int unsigned PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned UW = $clog2(CAPACITY + 1);
    localparam int unsigned LW = $clog2(MAX_READ + 1);
    localparam int unsigned CW = (UW > LW) ? UW : LW;
    localparam logic [PW-1:0] PTR_LAST = PW'(CAPACITY - 1);
    localparam logic [UW-1:0] CAP_U    = UW'(CAPACITY);
    localparam logic [6:0]    MAXR_7   = 7'(MAX_READ);
    localparam logic [LW-1:0] MAXR_L   = LW'(MAX_READ);

    // Byte store
    logic [7:0] mem [CAPACITY];
    logic [7:0] rd_data_reg;
    logic       mem_we;

    // Configuration
    logic [31:0] fs_reg, sid_reg;

    // Buffer state
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [UW-1:0] unread_reg, unread_next;
    logic [31:0]   pos_reg, pos_next;
    logic          eof_reg, eof_next;
    logic          seeking_reg, seeking_next;

    // Captured input item
    logic [2:0]    act_reg;
    logic [7:0]    byte_reg;
    logic          chunk_reg;
    logic [LW-1:0] len_reg;
    logic [1:0]    mode_reg;
    logic [32:0]   off_reg;
    logic          eofv_reg;
    logic [LW-1:0] len_sat;

    // Read bookkeeping
    logic [LW-1:0] rem_reg, rem_next;
    logic          dreq_reg, dreq_next;
    logic          empty_reg, empty_next;
    logic [CW-1:0] len_ext, un_ext, n_ext;
    logic [LW-1:0] n_cnt;

    // Seek arithmetic
    logic [34:0]   off_ext, target_calc, target_reg;
    logic          bad_calc, bad_reg;
    logic          sk_ok;

    // Result register
    logic          ov_reg, ov_next;
    logic [2:0]    kind_reg, kind_next;
    logic [7:0]    rbyte_reg, rbyte_next;
    logic          last_reg, last_next;
    logic          acc_reg, acc_next;
    logic [31:0]   opos_reg, opos_next;
    logic          sreq_reg, sreq_next;
    logic          odreq_reg, odreq_next;
    logic [UW-1:0] ocnt_reg, ocnt_next;
    logic [31:0]   tag_reg, tag_next;
    logic          out_load;
    logic [UW+12:0] ocnt_wide;

    // Saturate the requested length
    assign len_sat = (in_read_length > MAXR_7) ? MAXR_L : in_read_length[LW-1:0];

    // Size the read: min of length and unread bytes
    assign len_ext = CW'(len_reg);
    assign un_ext  = CW'(unread_reg);
    assign n_ext   = (len_ext < un_ext) ? len_ext : un_ext;
    assign n_cnt   = n_ext[LW-1:0];

    // Seek target from the chosen origin
    assign off_ext = {{2{off_reg[32]}}, off_reg};
    always_comb begin
        bad_calc = 1'b0;
        unique case (mode_reg)
            SEEK_START: target_calc = off_ext;
            SEEK_CUR:   target_calc = {3'b000, pos_reg} + off_ext;
            SEEK_END:   target_calc = {3'b000, fs_reg} + ~off_ext;
            default: begin
                target_calc = '0;
                bad_calc    = 1'b1;
            end
        endcase
    end
    assign sk_ok = !bad_reg && !target_reg[34] && (target_reg[33:0] <= {2'b00, fs_reg});

    assign out_load = cmd.wr_do | cmd.rd_emit | cmd.rd_short | cmd.sk_finish | cmd.misc_do;

    // Next state and result values
    always_comb begin
        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        unread_next  = unread_reg;
        pos_next     = pos_reg;
        eof_next     = eof_reg;
        seeking_next = seeking_reg;
        rem_next     = rem_reg;
        dreq_next    = dreq_reg;
        empty_next   = empty_reg;
        mem_we       = 1'b0;

        kind_next  = K_DONE;
        rbyte_next = 8'd0;
        last_next  = 1'b1;
        acc_next   = 1'b0;
        sreq_next  = 1'b0;
        odreq_next = 1'b0;
        tag_next   = 32'd0;

        if (cmd.wr_do) begin
            if (unread_reg < CAP_U) begin
                mem_we      = 1'b1;
                wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
                unread_next = unread_reg + 1'b1;
                acc_next    = 1'b1;
            end
            if (chunk_reg) begin
                seeking_next = 1'b0;
            end
            kind_next = K_WACK;
        end

        if (cmd.rd_start) begin
            rem_next    = n_cnt;
            dreq_next   = !eof_reg && (len_ext > un_ext);
            empty_next  = (unread_reg == '0);
            unread_next = unread_reg - UW'(n_cnt);
            pos_next    = pos_reg + 32'(n_cnt);
        end

        if (cmd.rd_short) begin
            kind_next  = empty_reg ? K_REMPTY : K_DONE;
            odreq_next = dreq_reg;
        end

        if (cmd.rd_emit) begin
            kind_next   = K_RBYTE;
            rbyte_next  = rd_data_reg;
            last_next   = (rem_reg == LW'(1));
            odreq_next  = dreq_reg;
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            rem_next    = rem_reg - 1'b1;
        end

        if (cmd.sk_finish) begin
            if (sk_ok) begin
                wr_ptr_next  = '0;
                rd_ptr_next  = '0;
                unread_next  = '0;
                pos_next     = target_reg[31:0];
                seeking_next = 1'b1;
                kind_next    = K_SOK;
                sreq_next    = 1'b1;
                tag_next     = sid_reg;
            end else begin
                kind_next = K_SFAIL;
            end
        end

        if (cmd.misc_do) begin
            priority if (act_reg == ACT_EOF) begin
                eof_next = eofv_reg;
            end else if (act_reg == ACT_RESET) begin
                wr_ptr_next  = '0;
                rd_ptr_next  = '0;
                unread_next  = '0;
                pos_next     = 32'd0;
                seeking_next = 1'b0;
            end else begin
                eof_next = eof_reg;
            end
        end

        opos_next = pos_next;
        ocnt_next = unread_next;

        // Hold the result until transferred
        if (out_load) begin
            ov_next = 1'b1;
        end else if (out_ready) begin
            ov_next = 1'b0;
        end else begin
            ov_next = ov_reg;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            unread_reg  <= '0;
            pos_reg     <= 32'd0;
            eof_reg     <= 1'b0;
            seeking_reg <= 1'b0;
            fs_reg      <= 32'd0;
            sid_reg     <= 32'd0;
            ov_reg      <= 1'b0;
        end else begin
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            unread_reg  <= unread_next;
            pos_reg     <= pos_next;
            eof_reg     <= eof_next;
            seeking_reg <= seeking_next;
            ov_reg      <= ov_next;
            if (cfg_we && cfg_index == CFG_FILE_SIZE) begin
                fs_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_SESSION_ID) begin
                sid_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            act_reg   <= in_action;
            byte_reg  <= in_data_byte;
            chunk_reg <= in_chunk_last;
            len_reg   <= len_sat;
            mode_reg  <= in_seek_mode;
            off_reg   <= in_seek_offset;
            eofv_reg  <= in_eof_value;
        end
        if (cmd.sk_calc) begin
            target_reg <= target_calc;
            bad_reg    <= bad_calc;
        end
        rem_reg   <= rem_next;
        dreq_reg  <= dreq_next;
        empty_reg <= empty_next;
        if (out_load) begin
            kind_reg  <= kind_next;
            rbyte_reg <= rbyte_next;
            last_reg  <= last_next;
            acc_reg   <= acc_next;
            opos_reg  <= opos_next;
            sreq_reg  <= sreq_next;
            odreq_reg <= odreq_next;
            ocnt_reg  <= ocnt_next;
            tag_reg   <= tag_next;
        end
    end

    // Byte store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_ptr_reg] <= byte_reg;
        end
        if (cmd.rd_fetch) begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    assign ocnt_wide = {13'd0, ocnt_reg};

    assign st.out_free = !ov_reg || out_ready;
    assign st.rd_none  = (n_cnt == '0);
    assign st.rd_last  = (rem_reg == LW'(1));

    assign out_valid        = ov_reg;
    assign out_kind         = kind_reg;
    assign out_read_byte    = rbyte_reg;
    assign out_last         = last_reg;
    assign out_accepted     = acc_reg;
    assign out_position     = opos_reg;
    assign out_seek_request = sreq_reg;
    assign out_data_request = odreq_reg;
    assign out_unread_count = ocnt_wide[12:0];
    assign out_session_tag  = tag_reg;
    assign seeking          = seeking_reg;

endmodule

>>> design/seekable_byte_ring_buffer_unit.sv
// Channel   Handshake             Payload
// s_        s_valid / s_ready     action, data_byte, chunk_last, read_length,
//                                 seek_mode, seek_offset, eof_value
// m_        m_valid / m_ready     kind, read_byte, last, accepted, position,
//                                 seek_request, data_request, unread_count, session_tag
// cfg_      cfg_valid / cfg_ready cfg_index, cfg_data (always ready)
//
// In a read, each byte goes through the store's registered read port before it is
// loaded into the result register.
// Reset is synchronous, active low; the byte store is not cleared.
// One item is worked at a time; the next is accepted while the last result
// still waits in the result register, and work stalls while that register is full.
// Top level; depends on sbrb_pkg, sbrb_ctrl and sbrb_datapath.
module seekable_byte_ring_buffer_unit #(
    parameter int unsigned CAPACITY = 4096,
    parameter int unsigned MAX_READ = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sbrb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                     cfg_data,
    // input items
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [2:0]                      s_action,
    input  logic [7:0]                      s_data_byte,
    input  logic                            s_chunk_last,
    input  logic [6:0]                      s_read_length,
    input  logic [1:0]                      s_seek_mode,
    input  logic signed [32:0]              s_seek_offset,
    input  logic                            s_eof_value,
    // result items
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [2:0]                      m_kind,
    output logic [7:0]                      m_read_byte,
    output logic                            m_last,
    output logic                            m_accepted,
    output logic [31:0]                     m_position,
    output logic                            m_seek_request,
    output logic                            m_data_request,
    output logic [12:0]                     m_unread_count,
    output logic [31:0]                     m_session_tag
);
    import sbrb_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t st;
    logic       seeking;

    assign cfg_ready = 1'b1;

    sbrb_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_action (s_action),
        .st        (st),
        .in_ready  (s_ready),
        .cmd       (cmd)
    );

    sbrb_datapath #(
        .CAPACITY (CAPACITY),
        .MAX_READ (MAX_READ)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .st               (st),
        .cfg_we           (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_action        (s_action),
        .in_data_byte     (s_data_byte),
        .in_chunk_last    (s_chunk_last),
        .in_read_length   (s_read_length),
        .in_seek_mode     (s_seek_mode),
        .in_seek_offset   (s_seek_offset),
        .in_eof_value     (s_eof_value),
        .out_ready        (m_ready),
        .out_valid        (m_valid),
        .out_kind         (m_kind),
        .out_read_byte    (m_read_byte),
        .out_last         (m_last),
        .out_accepted     (m_accepted),
        .out_position     (m_position),
        .out_seek_request (m_seek_request),
        .out_data_request (m_data_request),
        .out_unread_count (m_unread_count),
        .out_session_tag  (m_session_tag),
        .seeking          (seeking)
    );

`ifndef ASSERT_OFF
    // An accepted item blocks the input until its work is done
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while an item is in progress");

    // Only read bytes come in runs; every other result closes its item
    a_single_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind != K_RBYTE) |-> m_last)
        else $error("non-read result without last");

    // A successful seek shows a request and leaves the buffer in seeking mode
    a_seek_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == K_SOK) |-> (m_seek_request && seeking && m_unread_count == 13'd0))
        else $error("seek ok result inconsistent with buffer state");
`endif

endmodule

>>> verif/seekable_byte_ring_buffer_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for seekable_byte_ring_buffer_unit: directed table, a fill and
// drain pass over the whole store, then random traffic against a local buffer predictor.
// Depends on sbrb_pkg and the RTL of seekable_byte_ring_buffer_unit.
module seekable_byte_ring_buffer_unit_tb;
    import sbrb_pkg::*;

    localparam int unsigned CAP      = 4096;
    localparam int unsigned READ_MAX = 64;
    // Codes the package leaves unnamed
    localparam logic [1:0] SEEK_BAD     = 2'd3;
    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  data_byte;
        logic        chunk_last;
        logic [6:0]  read_length;
        logic [1:0]  seek_mode;
        logic [32:0] seek_offset;
        logic        eof_value;
    } ring_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  read_byte;
        logic        last;
        logic        accepted;
        logic [31:0] position;
        logic        seek_request;
        logic        data_request;
        logic [12:0] unread_count;
        logic [31:0] session_tag;
    } ring_result_t;

    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] cfg_idx;
        logic [31:0]          cfg_val;
        ring_item_t           item;
        logic                 typed;
        ring_result_t         res;
    } dir_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [2:0]           s_action = '0;
    logic [7:0]           s_data_byte = '0;
    logic                 s_chunk_last = 1'b0;
    logic [6:0]           s_read_length = '0;
    logic [1:0]           s_seek_mode = '0;
    logic signed [32:0]   s_seek_offset = '0;
    logic                 s_eof_value = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [2:0]           m_kind;
    logic [7:0]           m_read_byte;
    logic                 m_last;
    logic                 m_accepted;
    logic [31:0]          m_position;
    logic                 m_seek_request;
    logic                 m_data_request;
    logic [12:0]          m_unread_count;
    logic [31:0]          m_session_tag;

    // Predicted buffer state and registers
    logic [7:0]   mirror_mem [CAP];
    int unsigned  mir_wr, mir_rd, mir_count;
    logic [31:0]  mir_pos;
    logic         mir_eof, mir_seeking;
    logic [31:0]  reg_file_size, reg_session;

    ring_result_t ring_results_due [$];
    ring_result_t step_out [$];
    dir_row_t     dir_rows [$];
    int unsigned  mismatch_count = 0;
    int unsigned  items_sent = 0;
    int unsigned  tx_calm = 0, rx_calm = 0, rx_stall = 0;
    ring_result_t seen, want;

    seekable_byte_ring_buffer_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_data_byte(s_data_byte), .s_chunk_last(s_chunk_last),
        .s_read_length(s_read_length), .s_seek_mode(s_seek_mode),
        .s_seek_offset(s_seek_offset), .s_eof_value(s_eof_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind),
        .m_read_byte(m_read_byte), .m_last(m_last), .m_accepted(m_accepted),
        .m_position(m_position), .m_seek_request(m_seek_request),
        .m_data_request(m_data_request), .m_unread_count(m_unread_count),
        .m_session_tag(m_session_tag)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 0;
    end

    // Gap length: mostly none or short, a few long, and calm stretches with none
    function automatic int unsigned pick_gap(inout int unsigned calm);
        int unsigned r;
        if (calm != 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            calm = $urandom_range(20, 120);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(15, 30);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s got %0h, awaited %0h", name, got, exp_val));
    endtask

    // Post one predicted result, carrying the state after the step
    task automatic post_res(input logic [2:0] kind, input logic [7:0] rbyte, input logic last,
                            input logic acc, input logic sreq, input logic dreq,
                            input logic [31:0] tag);
        ring_result_t r;
        r = '{kind, rbyte, last, acc, mir_pos, sreq, dreq, 13'(mir_count), tag};
        step_out.push_back(r);
    endtask

    // Apply one item to the predicted buffer and collect its results in step_out
    task automatic ring_predict_op(input ring_item_t it);
        int unsigned        len, n;
        logic               dreq, ok, acc;
        logic signed [34:0] tgt, ofs, fsz;
        step_out.delete();
        case (it.action)
            ACT_WRITE: begin
                acc = 1'b0;
                if (mir_count < CAP) begin
                    mirror_mem[mir_wr] = it.data_byte;
                    mir_wr = (mir_wr == CAP - 1) ? 0 : mir_wr + 1;
                    mir_count++;
                    acc = 1'b1;
                end
                if (it.chunk_last) mir_seeking = 1'b0;
                post_res(K_WACK, 8'h00, 1'b1, acc, 1'b0, 1'b0, 32'h0);
            end
            ACT_READ: begin
                len  = (it.read_length > READ_MAX) ? READ_MAX : it.read_length;
                dreq = !mir_eof && (len > mir_count);
                if (mir_count == 0) begin
                    post_res(K_REMPTY, 8'h00, 1'b1, 1'b0, 1'b0, dreq, 32'h0);
                end else if (len == 0) begin
                    post_res(K_DONE, 8'h00, 1'b1, 1'b0, 1'b0, dreq, 32'h0);
                end else begin
                    n = (len < mir_count) ? len : mir_count;
                    mir_count -= n;
                    mir_pos += n;
                    for (int unsigned i = 0; i < n; i++) begin
                        post_res(K_RBYTE, mirror_mem[mir_rd], i == n - 1, 1'b0, 1'b0, dreq,
                                 32'h0);
                        mir_rd = (mir_rd == CAP - 1) ? 0 : mir_rd + 1;
                    end
                end
            end
            ACT_SEEK: begin
                ofs = {{2{it.seek_offset[32]}}, it.seek_offset};
                fsz = {3'b000, reg_file_size};
                ok  = 1'b1;
                case (it.seek_mode)
                    SEEK_START: tgt = ofs;
                    SEEK_CUR:   tgt = {3'b000, mir_pos} + ofs;
                    SEEK_END:   tgt = fsz - ofs - 35'sd1;
                    default: begin
                        tgt = '0;
                        ok  = 1'b0;
                    end
                endcase
                if (!ok || tgt < 0 || tgt > fsz) begin
                    post_res(K_SFAIL, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0);
                end else begin
                    mir_wr = 0;
                    mir_rd = 0;
                    mir_count = 0;
                    mir_pos = tgt[31:0];
                    mir_seeking = 1'b1;
                    post_res(K_SOK, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0, reg_session);
                end
            end
            default: begin
                if (it.action == ACT_EOF) begin
                    mir_eof = it.eof_value;
                end else if (it.action == ACT_RESET) begin
                    mir_wr = 0;
                    mir_rd = 0;
                    mir_count = 0;
                    mir_pos = '0;
                    mir_seeking = 1'b0;
                end
                post_res(K_DONE, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0);
            end
        endcase
    endtask

    // Item builders: unused fields carry random junk
    function automatic ring_item_t junk_item();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[54:0];
    endfunction

    function automatic ring_item_t op_write(input logic [7:0] b, input logic cl);
        ring_item_t it;
        it = junk_item();
        it.action = ACT_WRITE;
        it.data_byte = b;
        it.chunk_last = cl;
        return it;
    endfunction

    function automatic ring_item_t op_read(input logic [6:0] len);
        ring_item_t it;
        it = junk_item();
        it.action = ACT_READ;
        it.read_length = len;
        return it;
    endfunction

    function automatic ring_item_t op_seek(input logic [1:0] mode, input logic [32:0] off);
        ring_item_t it;
        it = junk_item();
        it.action = ACT_SEEK;
        it.seek_mode = mode;
        it.seek_offset = off;
        return it;
    endfunction

    function automatic ring_item_t op_misc(input logic [2:0] act, input logic ev);
        ring_item_t it;
        it = junk_item();
        it.action = act;
        it.eof_value = ev;
        return it;
    endfunction

    function automatic ring_result_t mk_res(input logic [2:0] kind, input logic acc,
                                            input logic [31:0] pos, input logic sreq,
                                            input logic dreq, input logic [12:0] unread,
                                            input logic [31:0] tag);
        return '{kind, 8'h00, 1'b1, acc, pos, sreq, dreq, unread, tag};
    endfunction

    function automatic logic [6:0] rand_read_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5) return 7'd0;
        if (r < 80) return 7'($urandom_range(1, 32));
        if (r < 92) return 7'($urandom_range(33, 64));
        return 7'($urandom_range(65, 127));
    endfunction

    // Table rows
    task automatic t_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        dir_rows.push_back('{1'b1, idx, val, ring_item_t'('0), 1'b0, ring_result_t'('0)});
    endtask

    task automatic t_op(input ring_item_t it);
        dir_rows.push_back('{1'b0, CFG_FILE_SIZE, 32'h0, it, 1'b0, ring_result_t'('0)});
    endtask

    task automatic t_chk(input ring_item_t it, input ring_result_t res);
        dir_rows.push_back('{1'b0, CFG_FILE_SIZE, 32'h0, it, 1'b1, res});
    endtask

    // Present one item, hold it until the transfer, then predict its results
    task automatic send_item(input ring_item_t it, input logic typed = 1'b0,
                             input ring_result_t preset = '0);
        int unsigned gap;
        gap = pick_gap(tx_calm);
        @(negedge aclk);
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_action = it.action;
        s_data_byte = it.data_byte;
        s_chunk_last = it.chunk_last;
        s_read_length = it.read_length;
        s_seek_mode = it.seek_mode;
        s_seek_offset = it.seek_offset;
        s_eof_value = it.eof_value;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        ring_predict_op(it);
        if (typed) ring_results_due.push_back(preset);
        else foreach (step_out[i]) ring_results_due.push_back(step_out[i]);
        items_sent++;
    endtask

    // Drop valid and wait until every awaited result has arrived
    task automatic wait_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (ring_results_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_FILE_SIZE) reg_file_size = val;
        else if (idx == CFG_SESSION_ID) reg_session = val;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // One random stretch: mostly write bursts followed by a read, plus seeks and noise
    task automatic random_sequence();
        int unsigned r, k;
        logic [31:0] tgt;
        logic [32:0] off;
        logic [1:0]  mode;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            k = $urandom_range(1, 24);
            for (int unsigned j = 0; j < k; j++)
                send_item(op_write(8'($urandom()),
                                   (j == k - 1) || ($urandom_range(0, 15) == 0)));
            send_item(op_read(rand_read_len()));
        end else if (r < 70) begin
            send_item(op_read(rand_read_len()));
        end else if (r < 80) begin
            // well-formed seek to a target inside the file
            tgt = $urandom_range(0, reg_file_size);
            case ($urandom_range(0, 2))
                0: begin
                    mode = SEEK_START;
                    off = {1'b0, tgt};
                end
                1: begin
                    mode = SEEK_CUR;
                    off = {1'b0, tgt} - {1'b0, mir_pos};
                end
                default: begin
                    mode = SEEK_END;
                    off = {1'b0, reg_file_size} - {1'b0, tgt} - 33'd1;
                end
            endcase
            send_item(op_seek(mode, off));
        end else if (r < 85) begin
            send_item(op_seek(2'($urandom_range(0, 3)), {1'($urandom()), $urandom()}));
        end else if (r < 90) begin
            send_item(op_misc(ACT_EOF, 1'($urandom())));
        end else if (r < 93) begin
            send_item(op_misc(ACT_RESET, 1'($urandom())));
        end else if (r < 96) begin
            send_item(op_misc(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)),
                              1'($urandom())));
        end else begin
            send_item(junk_item());
        end
    endtask

    task automatic k_loop(input int unsigned stop_at);
        while (items_sent < stop_at) random_sequence();
    endtask

    // Receiver: random stalls on ready
    always @(negedge aclk) begin
        if (rx_stall != 0) begin
            m_ready = 1'b0;
            rx_stall--;
        end else begin
            m_ready = 1'b1;
            rx_stall = pick_gap(rx_calm);
        end
    end

    // Check each result transfer against the oldest awaited result
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen = '{m_kind, m_read_byte, m_last, m_accepted, m_position, m_seek_request,
                     m_data_request, m_unread_count, m_session_tag};
            if (ring_results_due.size() == 0) begin
                report_mismatch($sformatf("result with none awaited: kind %0d pos %0h",
                                          m_kind, m_position));
            end else begin
                want = ring_results_due.pop_front();
                check_field("kind", seen.kind, want.kind);
                check_field("read_byte", seen.read_byte, want.read_byte);
                check_field("last", seen.last, want.last);
                check_field("accepted", seen.accepted, want.accepted);
                check_field("position", seen.position, want.position);
                check_field("seek_request", seen.seek_request, want.seek_request);
                check_field("data_request", seen.data_request, want.data_request);
                check_field("unread_count", seen.unread_count, want.unread_count);
                check_field("session_tag", seen.session_tag, want.session_tag);
            end
        end
    end

    initial begin
        #40_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        mir_wr = 0;
        mir_rd = 0;
        mir_count = 0;
        mir_pos = '0;
        mir_eof = 1'b0;
        mir_seeking = 1'b0;
        reg_file_size = '0;
        reg_session = '0;

        // Directed table: empty reads, extremes, eof, seek failures, position wrap
        t_cfg(CFG_FILE_SIZE, 32'hFFFF_FFFF);
        t_cfg(CFG_SESSION_ID, 32'hFFFF_FFFF);
        t_chk(op_read(7'd1), mk_res(K_REMPTY, 1'b0, 32'd0, 1'b0, 1'b1, 13'd0, 32'd0));
        t_chk(op_read(7'd0), mk_res(K_REMPTY, 1'b0, 32'd0, 1'b0, 1'b0, 13'd0, 32'd0));
        t_chk(op_write(8'h00, 1'b0), mk_res(K_WACK, 1'b1, 32'd0, 1'b0, 1'b0, 13'd1, 32'd0));
        t_chk(op_write(8'hFF, 1'b1), mk_res(K_WACK, 1'b1, 32'd0, 1'b0, 1'b0, 13'd2, 32'd0));
        t_chk(op_read(7'd0), mk_res(K_DONE, 1'b0, 32'd0, 1'b0, 1'b0, 13'd2, 32'd0));
        t_op(op_read(7'd127));
        t_chk(op_misc(ACT_EOF, 1'b1), mk_res(K_DONE, 1'b0, 32'd2, 1'b0, 1'b0, 13'd0, 32'd0));
        t_chk(op_read(7'd5), mk_res(K_REMPTY, 1'b0, 32'd2, 1'b0, 1'b0, 13'd0, 32'd0));
        t_op(op_write(8'hA5, 1'b0));
        t_op(op_read(7'd64));
        t_chk(op_misc(ACT_EOF, 1'b0), mk_res(K_DONE, 1'b0, 32'd3, 1'b0, 1'b0, 13'd0, 32'd0));
        t_chk(op_seek(SEEK_BAD, 33'd0),
              mk_res(K_SFAIL, 1'b0, 32'd3, 1'b0, 1'b0, 13'd0, 32'd0));
        t_chk(op_seek(SEEK_START, 33'h1_FFFF_FFFF),
              mk_res(K_SFAIL, 1'b0, 32'd3, 1'b0, 1'b0, 13'd0, 32'd0));
        t_chk(op_seek(SEEK_CUR, 33'h1_0000_0000),
              mk_res(K_SFAIL, 1'b0, 32'd3, 1'b0, 1'b0, 13'd0, 32'd0));
        t_chk(op_seek(SEEK_END, 33'h1_FFFF_FFFE),
              mk_res(K_SFAIL, 1'b0, 32'd3, 1'b0, 1'b0, 13'd0, 32'd0));
        t_chk(op_seek(SEEK_START, 33'h0_FFFF_FFFE),
              mk_res(K_SOK, 1'b0, 32'hFFFF_FFFE, 1'b1, 1'b0, 13'd0, 32'hFFFF_FFFF));
        t_op(op_write(8'h5A, 1'b0));
        t_op(op_write(8'h3C, 1'b0));
        t_op(op_write(8'hC3, 1'b1));
        t_op(op_read(7'd3));
        t_op(op_seek(SEEK_CUR, 33'h1_FFFF_FFFF));
        t_op(op_seek(SEEK_CUR, 33'h0_FFFF_FFFF));
        t_cfg(CFG_FILE_SIZE, 32'd0);
        t_cfg(CFG_SESSION_ID, 32'd0);
        t_chk(op_seek(SEEK_END, 33'h1_FFFF_FFFF),
              mk_res(K_SOK, 1'b0, 32'd0, 1'b1, 1'b0, 13'd0, 32'd0));
        t_chk(op_seek(SEEK_START, 33'd1),
              mk_res(K_SFAIL, 1'b0, 32'd0, 1'b0, 1'b0, 13'd0, 32'd0));
        t_chk(op_misc(ACT_RESET, 1'b0), mk_res(K_DONE, 1'b0, 32'd0, 1'b0, 1'b0, 13'd0, 32'd0));
        t_chk(op_misc(ACT_SPARE_LO, 1'b1),
              mk_res(K_DONE, 1'b0, 32'd0, 1'b0, 1'b0, 13'd0, 32'd0));

        // Hold reset, then release at a falling edge
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                wait_idle();
                write_reg(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
            end else begin
                send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);
            end
        end

        // Offset the pointers, fill past full so both pointers wrap, then drain
        for (int i = 0; i < 10; i++) send_item(op_write(8'($urandom()), 1'b0));
        send_item(op_read(7'd10));
        for (int i = 0; i < CAP + 2; i++)
            send_item(op_write(8'($urandom()), i >= CAP));
        while (mir_count != 0) send_item(op_read(7'd64));
        send_item(op_read(7'd64));

        // Random traffic in four register settings
        for (int ph = 0; ph < 4; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    write_reg(CFG_FILE_SIZE, 32'd1000);
                    write_reg(CFG_SESSION_ID, $urandom());
                end
                1: begin
                    write_reg(CFG_FILE_SIZE, 32'hFFFF_FFFF);
                    write_reg(CFG_SESSION_ID, 32'hFFFF_FFFF);
                end
                2: begin
                    write_reg(CFG_FILE_SIZE, 32'd0);
                    write_reg(CFG_SESSION_ID, 32'd0);
                end
                default: begin
                    write_reg(CFG_FILE_SIZE, $urandom());
                    write_reg(CFG_SESSION_ID, $urandom());
                end
            endcase
            k_loop(items_sent + 100);
        end

        // Drain and allow for the longest read to finish
        wait_idle();
        repeat (150) @(posedge aclk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
